FILE: sv/rlm_pkg.sv
package rlm_pkg;

   // waiter queue and id geometry
   localparam int WAIT_DEPTH = 16;
   localparam int ID_BITS    = 8;
   localparam int PTR_BITS   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int CNT_BITS   = $clog2(WAIT_DEPTH + 1);

   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(WAIT_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(WAIT_DEPTH);

   // handoff queue between front and back, depth a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_ACQUIRE = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_QUERY   = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      OP_ACQUIRE,
      OP_RELEASE,
      OP_QUERY
   } op_type;

   typedef enum logic [2:0] {
      ST_GRANTED   = 3'd0,
      ST_ALREADY   = 3'd1,
      ST_QUEUED    = 3'd2,
      ST_FREED     = 3'd3,
      ST_HANDED    = 3'd4,
      ST_NOT_OWNER = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_FETCH
   } back_state_type;

   typedef struct packed {
      op_type             op;
      logic [ID_BITS-1:0] client;
      logic [ID_BITS-1:0] thread;
   } item_type;

endpackage

FILE: sv/rlm_front.sv
module rlm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_command,
   input  logic [rlm_pkg::ID_BITS-1:0] req_client_id,
   input  logic [rlm_pkg::ID_BITS-1:0] req_thread_id,
   output logic                        item_valid,
   output rlm_pkg::item_type           item,
   input  logic                        item_pop
);
   import rlm_pkg::*;

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   item_type               decoded;
   logic                   push, pop;

   // classify the command; the unused code behaves as a query
   always_comb begin
      decoded.client = req_client_id;
      decoded.thread = req_thread_id;
      case (req_command)
         CMD_ACQUIRE: decoded.op = OP_ACQUIRE;
         CMD_RELEASE: decoded.op = OP_RELEASE;
         default:     decoded.op = OP_QUERY;
      endcase
   end

   assign req_ready  = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

FILE: sv/rlm_back.sv
module rlm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  rlm_pkg::item_type           item,
   output logic                        item_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_busy_res,
   output logic                        rsp_held_by_requester,
   output logic                        rsp_notify_valid,
   output logic [rlm_pkg::ID_BITS-1:0] rsp_notify_client,
   output logic [rlm_pkg::ID_BITS-1:0] rsp_notify_thread
);
   import rlm_pkg::*;

   back_state_type          state_ff, state_in;
   logic                    busy_ff, busy_in;
   logic [ID_BITS-1:0]      owner_c_ff, owner_c_in;
   logic [ID_BITS-1:0]      owner_t_ff, owner_t_in;
   logic [PTR_BITS-1:0]     head_ff, head_in;
   logic [PTR_BITS-1:0]     tail_ff, tail_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;

   logic [2*ID_BITS-1:0]    mem [WAIT_DEPTH];
   logic [2*ID_BITS-1:0]    head_rd_ff;
   logic                    push;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic                    busy_res_ff, busy_res_in;
   logic                    held_ff, held_in;
   logic                    nvalid_ff, nvalid_in;
   logic [ID_BITS-1:0]      nclient_ff, nclient_in;
   logic [ID_BITS-1:0]      nthread_ff, nthread_in;
   logic                    load;

   logic                    out_free, is_owner, handover;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_owner = busy_ff && (owner_c_ff == item.client) && (owner_t_ff == item.thread);
   assign handover = (item.op == OP_RELEASE) && is_owner && (count_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (item_valid && out_free && handover) begin
               state_in = BK_FETCH;
            end
         end
         BK_FETCH: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and lock state updates
   always_comb begin
      item_pop    = 1'b0;
      load        = 1'b0;
      push        = 1'b0;
      busy_in     = busy_ff;
      owner_c_in  = owner_c_ff;
      owner_t_in  = owner_t_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      status_in   = ST_GRANTED;
      busy_res_in = busy_ff;
      held_in     = 1'b0;
      nvalid_in   = 1'b0;
      nclient_in  = '0;
      nthread_in  = '0;
      case (state_ff)
         BK_IDLE: begin
            if (item_valid && out_free && !handover) begin
               item_pop = 1'b1;
               load     = 1'b1;
               case (item.op)
                  OP_ACQUIRE: begin
                     if (is_owner) begin
                        status_in = ST_ALREADY;
                        held_in   = 1'b1;
                     end else if (!busy_ff) begin
                        status_in   = ST_GRANTED;
                        busy_in     = 1'b1;
                        owner_c_in  = item.client;
                        owner_t_in  = item.thread;
                        busy_res_in = 1'b1;
                        held_in     = 1'b1;
                     end else if (count_ff < FULL_COUNT) begin
                        status_in = ST_QUEUED;
                        push      = 1'b1;
                        tail_in   = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
                        count_in  = count_ff + 1'b1;
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  OP_RELEASE: begin
                     if (!is_owner) begin
                        status_in = ST_NOT_OWNER;
                     end else begin
                        // owner leaves with nobody waiting
                        status_in   = ST_FREED;
                        busy_in     = 1'b0;
                        owner_c_in  = '0;
                        owner_t_in  = '0;
                        busy_res_in = 1'b0;
                     end
                  end
                  default: begin
                     status_in = ST_GRANTED;
                     held_in   = is_owner;
                  end
               endcase
            end
         end
         BK_FETCH: begin
            // head entry read last cycle, hand the lock over
            if (out_free) begin
               item_pop    = 1'b1;
               load        = 1'b1;
               owner_c_in  = head_rd_ff[2*ID_BITS-1:ID_BITS];
               owner_t_in  = head_rd_ff[ID_BITS-1:0];
               head_in     = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
               count_in    = count_ff - 1'b1;
               status_in   = ST_HANDED;
               busy_res_in = 1'b1;
               held_in     = (owner_c_in == item.client) && (owner_t_in == item.thread);
               nvalid_in   = 1'b1;
               nclient_in  = owner_c_in;
               nthread_in  = owner_t_in;
            end
         end
         default: begin
            item_pop = 1'b0;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         busy_ff      <= 1'b0;
         owner_c_ff   <= '0;
         owner_t_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         owner_c_ff   <= owner_c_in;
         owner_t_ff   <= owner_t_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // waiter memory, registered read at the head
   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= {item.client, item.thread};
      end
      head_rd_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff   <= status_in;
         busy_res_ff <= busy_res_in;
         held_ff     <= held_in;
         nvalid_ff   <= nvalid_in;
         nclient_ff  <= nclient_in;
         nthread_ff  <= nthread_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_busy_res          = busy_res_ff;
   assign rsp_held_by_requester = held_ff;
   assign rsp_notify_valid      = nvalid_ff;
   assign rsp_notify_client     = nclient_ff;
   assign rsp_notify_thread     = nthread_ff;

endmodule

FILE: sv/remote_lock_manager_fifo_handoff.sv
// lock manager for one lock owned by a (client, thread) pair, with a fifo of waiters
//
// req channel: one beat per request, command acquire, release or query plus the ids
// rsp channel: exactly one beat per request, in request order: status, busy after the
//   request, whether the requester now owns the lock, and the new owner on hand-over
// a front stage decodes requests into a two-beat queue; the back stage owns the lock
//   state and the waiter memory and works one request at a time
// path: a request is registered in the handoff queue, then in the result register
// throughput: one request per cycle unless the receiver stalls; a release that hands the lock
//   to a waiter adds a fetch state in the back stage, as the waiter memory read at the head is registered
// reset: lock free, waiter queue empty, handoff queue empty, no result pending;
//   waiter memory content is left as it is and only pushed entries are ever read
// receiver stall: the result register holds its beat; the back stage stops, the
//   handoff queue fills and then req_ready drops
module remote_lock_manager_fifo_handoff (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_command,
   input  logic [rlm_pkg::ID_BITS-1:0] req_client_id,
   input  logic [rlm_pkg::ID_BITS-1:0] req_thread_id,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_busy_res,
   output logic                        rsp_held_by_requester,
   output logic                        rsp_notify_valid,
   output logic [rlm_pkg::ID_BITS-1:0] rsp_notify_client,
   output logic [rlm_pkg::ID_BITS-1:0] rsp_notify_thread
);
   import rlm_pkg::*;

   // decoded beats waiting for the back stage
   logic     item_valid;
   logic     item_pop;
   item_type item;

   rlm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_client_id (req_client_id),
      .req_thread_id (req_thread_id),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   // lock state, waiter memory and result register
   rlm_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .item_valid            (item_valid),
      .item                  (item),
      .item_pop              (item_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_held_by_requester (rsp_held_by_requester),
      .rsp_notify_valid      (rsp_notify_valid),
      .rsp_notify_client     (rsp_notify_client),
      .rsp_notify_thread     (rsp_notify_thread)
   );

endmodule

FILE: sv/rlm_checker.sv
module rlm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [2:0]                  rsp_status,
   input logic                        rsp_busy_res,
   input logic                        rsp_held_by_requester,
   input logic                        rsp_notify_valid,
   input logic [rlm_pkg::ID_BITS-1:0] rsp_notify_client,
   input logic [rlm_pkg::ID_BITS-1:0] rsp_notify_thread
);
   import rlm_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_notify_client) && $stable(rsp_notify_thread))
      else $error("result beat changed while stalled");

   // notification only on hand-over, and the lock stays busy
   a_notify: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_notify_valid |-> rsp_status == ST_HANDED && rsp_busy_res)
      else $error("notification without hand-over");

   a_notify_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_notify_valid |-> rsp_notify_client == '0 && rsp_notify_thread == '0)
      else $error("notify ids set without notification");

   // granted or already owned, with the requester holding the lock, means the lock is busy
   a_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_GRANTED || rsp_status == ST_ALREADY)
         && rsp_held_by_requester |-> rsp_busy_res)
      else $error("requester holds a free lock");

   a_freed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FREED |-> !rsp_busy_res && !rsp_held_by_requester)
      else $error("freed lock still busy");

endmodule

bind remote_lock_manager_fifo_handoff rlm_checker u_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_status            (rsp_status),
   .rsp_busy_res          (rsp_busy_res),
   .rsp_held_by_requester (rsp_held_by_requester),
   .rsp_notify_valid      (rsp_notify_valid),
   .rsp_notify_client     (rsp_notify_client),
   .rsp_notify_thread     (rsp_notify_thread)
);
